[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/spq_pkg.sv]
// Package with the shared codes and types of the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Operation codes carried by the func field.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Status codes reported with every result word.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DEQ_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_ENQ_FULL  = 2'd2;

  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned FILL_W  = 5;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// One storage cell of the queue chain: holds one entry and shifts with its neighbours.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire spq_ctrl_t         ctrl_i,
  input  wire logic              occ_i,
  input  wire logic [PRIO_W-1:0] new_prio_i,
  input  wire logic [TAG_W-1:0]  new_tag_i,
  input  wire logic              left_ins_i,
  input  wire logic [PRIO_W-1:0] left_prio_i,
  input  wire logic [TAG_W-1:0]  left_tag_i,
  input  wire logic [PRIO_W-1:0] right_prio_i,
  input  wire logic [TAG_W-1:0]  right_tag_i,
  output logic                   ins_o,
  output logic [PRIO_W-1:0]      prio_o,
  output logic [TAG_W-1:0]       tag_o
);

  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;

  // The new word belongs at or before this cell when the cell is free or
  // holds a strictly lower priority. Along the chain this flag is monotonic.
  assign ins_o = !occ_i || (prio_q < new_prio_i);

  // Select the next content: keep, shift right on insert, shift left on removal.
  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.enq) begin
      if (left_ins_i) begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end else if (ins_o) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end
    end else if (ctrl_i.deq) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

[src/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: a chain of entry cells and a result register.
//
//   channel | direction | handshake                 | word fields
//   req     | in        | req_valid_i / req_stall_o | func, priority_req, item_tag
//   rsp     | out       | rsp_valid_o / rsp_stall_i | out_valid, out_priority, out_tag,
//           |           |                           | status, fill_count, is_empty
//
// For every request word the whole chain of cells updates at the edge that
// accepts it, and its result word is shown from the next cycle on.
// One word per cycle is taken while results are consumed; the request side is
// stalled only while a result word is held under rsp_stall_i.
// Reset clears the fill count and the result valid flag; result payload and cell contents need none.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_stall_o,
  input  wire logic              func_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  input  wire logic [TAG_W-1:0]  item_tag_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_stall_i,
  output logic                   out_valid_o,
  output logic [PRIO_W-1:0]      out_priority_o,
  output logic [TAG_W-1:0]       out_tag_o,
  output logic [1:0]             status_o,
  output logic [FILL_W-1:0]      fill_count_o,
  output logic                   is_empty_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, full, empty, is_deq;
  spq_ctrl_t        ctrl;

  logic [PRIO_W-1:0] cell_prio [DEPTH];
  logic [TAG_W-1:0]  cell_tag  [DEPTH];
  logic [DEPTH-1:0]  cell_ins;

  logic                   rsp_valid_q;
  logic                   res_valid_q;
  logic [PRIO_W-1:0]      res_prio_q;
  logic [TAG_W-1:0]       res_tag_q;
  logic [1:0]             res_status_q, res_status_d;
  logic [FILL_W-1:0]      res_fill_q;
  logic                   res_empty_q;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  // Handshake and operation decode.
  assign req_stall_o = rsp_valid_q && rsp_stall_i;
  assign accept      = req_valid_i && !req_stall_o;
  assign is_deq      = (func_i == FUNC_DEQ);
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);
  assign ctrl.enq    = accept && !is_deq && !full;
  assign ctrl.deq    = accept && is_deq && !empty;

  // Chain of cells; a cell is occupied when its place lies below the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              left_ins;
    logic [PRIO_W-1:0] left_prio, right_prio;
    logic [TAG_W-1:0]  left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_ins  = 1'b0;
      assign left_prio = '0;
      assign left_tag  = '0;
    end else begin : g_body
      assign left_ins  = cell_ins[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_tag  = '0;
    end else begin : g_inner
      assign right_prio = cell_prio[i+1];
      assign right_tag  = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (CNT_W'(i) < count_q),
      .new_prio_i   (priority_req_i),
      .new_tag_i    (item_tag_i),
      .left_ins_i   (left_ins),
      .left_prio_i  (left_prio),
      .left_tag_i   (left_tag),
      .right_prio_i (right_prio),
      .right_tag_i  (right_tag),
      .ins_o        (cell_ins[i]),
      .prio_o       (cell_prio[i]),
      .tag_o        (cell_tag[i])
    );
  end

  // Fill count after the operation.
  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.deq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Status of the accepted word.
  always_comb begin
    res_status_d = STATUS_OK;
    if (accept && !is_deq && full) begin
      res_status_d = STATUS_ENQ_FULL;
    end else if (accept && is_deq && empty) begin
      res_status_d = STATUS_DEQ_EMPTY;
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_d};

  // Result register: valid flag with reset, payload loaded on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_valid_q  <= ctrl.deq;
      res_prio_q   <= ctrl.deq ? cell_prio[0] : '0;
      res_tag_q    <= ctrl.deq ? cell_tag[0] : '0;
      res_status_q <= res_status_d;
      res_fill_q   <= fill_ext[FILL_W-1:0];
      res_empty_q  <= (count_d == '0);
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign out_valid_o    = res_valid_q;
  assign out_priority_o = res_prio_q;
  assign out_tag_o      = res_tag_q;
  assign status_o       = res_status_q;
  assign fill_count_o   = res_fill_q;
  assign is_empty_o     = res_empty_q;

endmodule

`default_nettype wire

[src/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_stall_o,
  input wire logic              rsp_valid_o,
  input wire logic              rsp_stall_i,
  input wire logic              out_valid_o,
  input wire logic [PRIO_W-1:0] out_priority_o,
  input wire logic [TAG_W-1:0]  out_tag_o,
  input wire logic [1:0]        status_o,
  input wire logic [FILL_W-1:0] fill_count_o,
  input wire logic              is_empty_o
);

  logic [PRIO_W+TAG_W+FILL_W+3:0] rsp_word;
  logic                           rsp_wait;
  logic                           req_take;
  logic                           served_rsp;
  logic                           err_rsp;
  logic                           entry_clear;
  logic                           empty_rsp;

  // Conditions on the ports, gathered so that each check reads as one short line.
  assign rsp_word    = {out_valid_o, out_priority_o, out_tag_o, status_o, fill_count_o,
                        is_empty_o};
  assign rsp_wait    = rsp_valid_o && rsp_stall_i;
  assign req_take    = req_valid_i && !req_stall_o;
  assign served_rsp  = rsp_valid_o && out_valid_o;
  assign err_rsp     = rsp_valid_o && (status_o != STATUS_OK);
  assign entry_clear = !out_valid_o && (out_priority_o == '0) && (out_tag_o == '0);
  assign empty_rsp   = rst_ni && rsp_valid_o && is_empty_o;

  // A held result word keeps its contents while stalled.
  `ASSERT_CHK(a_rsp_hold, rsp_wait |=> rsp_valid_o && $stable(rsp_word), "held word changed")

  // Every accepted request word yields a result word in the next cycle.
  `ASSERT_CHK(a_req_to_rsp, req_take |=> rsp_valid_o, "no result word after a request")

  // A returned entry always comes with an ok status.
  `ASSERT_CHK(a_deq_ok, served_rsp |-> status_o == STATUS_OK, "entry with error status")

  // Error results carry no entry.
  `ASSERT_CHK(a_err_clear, err_rsp |-> entry_clear, "error result carries an entry")

  // An empty queue reports a zero fill count.
  `ASSERT_CHK_ALWAYS(a_empty_fill, empty_rsp |-> fill_count_o == '0, "empty with nonzero fill")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

`default_nettype wire

[tb/sorted_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the sorted priority queue unit, with its own queue model.
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned RANDOM_WORDS   = 1100;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic              func;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } req_word_t;

  typedef struct packed {
    logic              served;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill;
    logic              empty;
  } rsp_word_t;

  typedef enum int unsigned {FLOW_FREE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_style_e;

  // Stimulus and block ports.
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              req_valid_i    = 1'b0;
  logic              func_i         = FUNC_ENQ;
  logic [PRIO_W-1:0] priority_req_i = '0;
  logic [TAG_W-1:0]  item_tag_i     = '0;
  logic              rsp_stall_i    = 1'b0;
  logic              req_stall_o;
  logic              rsp_valid_o;
  logic              out_valid_o;
  logic [PRIO_W-1:0] out_priority_o;
  logic [TAG_W-1:0]  out_tag_o;
  logic [1:0]        status_o;
  logic [FILL_W-1:0] fill_count_o;
  logic              is_empty_o;

  // Words waiting to be sent, and results owed by the block.
  req_word_t pending_words[$];
  rsp_word_t results_due[$];
  req_word_t next_word;
  rsp_word_t oldest_due;
  logic      word_taken = 1'b0;

  // Model of the stored entries in service order.
  logic [PRIO_W-1:0] model_prio[QDEPTH];
  logic [TAG_W-1:0]  model_tag[QDEPTH];
  int                model_fill = 0;

  // Run statistics.
  int unsigned mismatches   = 0;
  int unsigned enq_count    = 0;
  int unsigned deq_count    = 0;
  int unsigned refused_full = 0;
  int unsigned empty_deqs   = 0;
  int unsigned peak_fill    = 0;
  int unsigned cycle_count  = 0;

  // Sender and receiver pacing.
  int unsigned  burst_left = 4;
  int unsigned  gap_left   = 0;
  int unsigned  stall_left = 0;
  stall_style_e stall_style = FLOW_FREE;

  sorted_priority_queue_unit #(.DEPTH(QDEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .func_i         (func_i),
    .priority_req_i (priority_req_i),
    .item_tag_i     (item_tag_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_stall_i    (rsp_stall_i),
    .out_valid_o    (out_valid_o),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o),
    .is_empty_o     (is_empty_o)
  );

  always #10 clk_i = ~clk_i;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Applies one request word to the model queue and returns the word it should produce.
  function automatic rsp_word_t serve_request(input req_word_t w);
    rsp_word_t r;
    int        slot;
    r = '0;
    if (w.func == FUNC_ENQ) begin
      enq_count++;
      if (model_fill >= QDEPTH) begin
        r.status = STATUS_ENQ_FULL;
        refused_full++;
      end else begin
        // The new entry goes before the first entry of strictly lower priority.
        slot = model_fill;
        for (int i = 0; i < model_fill; i++) begin
          if (model_prio[i] < w.prio && slot == model_fill) slot = i;
        end
        for (int i = model_fill; i > slot; i--) begin
          model_prio[i] = model_prio[i-1];
          model_tag[i]  = model_tag[i-1];
        end
        model_prio[slot] = w.prio;
        model_tag[slot]  = w.tag;
        model_fill++;
        if (model_fill > peak_fill) peak_fill = model_fill;
      end
    end else begin
      deq_count++;
      if (model_fill == 0) begin
        r.status = STATUS_DEQ_EMPTY;
        empty_deqs++;
      end else begin
        r.served = 1'b1;
        r.prio   = model_prio[0];
        r.tag    = model_tag[0];
        for (int i = 1; i < model_fill; i++) begin
          model_prio[i-1] = model_prio[i];
          model_tag[i-1]  = model_tag[i];
        end
        model_fill--;
      end
      if (r.status == STATUS_OK) r.status = STATUS_OK;
    end
    r.fill  = FILL_W'(model_fill);
    r.empty = (model_fill == 0);
    return r;
  endfunction

  task automatic queue_word(input logic func, input logic [PRIO_W-1:0] prio,
                            input logic [TAG_W-1:0] tag);
    req_word_t w;
    w.func = func;
    w.prio = prio;
    w.tag  = tag;
    pending_words.push_back(w);
  endtask

  // Driver: presents the pending words in bursts with random gaps between them.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else if (!req_valid_i || word_taken) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        req_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        next_word = pending_words.pop_front();
        req_valid_i    <= 1'b1;
        func_i         <= next_word.func;
        priority_req_i <= next_word.prio;
        item_tag_i     <= next_word.tag;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stalls on a pattern whose style is picked anew at random when each run of it ends.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_left  <= $urandom_range(5, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      FLOW_FREE:   rsp_stall_i <= 1'b0;
      STALL_LIGHT: rsp_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  rsp_stall_i <= ($urandom_range(0, 1) == 0);
      default:     rsp_stall_i <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // Monitor: checks each result word, then predicts the result of a word taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with none expected");
        end else begin
          oldest_due = results_due.pop_front();
          if (out_valid_o !== oldest_due.served)
            report_mismatch($sformatf("out_valid %b, expected %b", out_valid_o,
                                      oldest_due.served));
          if (out_priority_o !== oldest_due.prio)
            report_mismatch($sformatf("out_priority %h, expected %h", out_priority_o,
                                      oldest_due.prio));
          if (out_tag_o !== oldest_due.tag)
            report_mismatch($sformatf("out_tag %h, expected %h", out_tag_o, oldest_due.tag));
          if (status_o !== oldest_due.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o,
                                      oldest_due.status));
          if (fill_count_o !== oldest_due.fill)
            report_mismatch($sformatf("fill_count %0d, expected %0d", fill_count_o,
                                      oldest_due.fill));
          if (is_empty_o !== oldest_due.empty)
            report_mismatch($sformatf("is_empty %b, expected %b", is_empty_o,
                                      oldest_due.empty));
        end
      end
      if (req_valid_i && !req_stall_o) begin
        results_due.push_back(serve_request({func_i, priority_req_i, item_tag_i}));
      end
    end
    word_taken <= rst_ni && req_valid_i && !req_stall_o;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus, end of run and verdict.
  initial begin
    int unsigned queued;
    int unsigned phase_len;
    int unsigned enq_pct;
    req_word_t   w;

    // Directed: empty dequeue, extreme priorities and tags, ties kept in arrival order.
    queue_word(FUNC_DEQ, 16'hFFFF, 16'hFFFF);
    queue_word(FUNC_ENQ, 16'h0000, 16'h0000);
    queue_word(FUNC_ENQ, 16'hFFFF, 16'hFFFF);
    queue_word(FUNC_ENQ, 16'h8000, 16'h1111);
    queue_word(FUNC_ENQ, 16'h8000, 16'h2222);
    queue_word(FUNC_ENQ, 16'h8000, 16'h3333);
    queue_word(FUNC_ENQ, 16'h0001, 16'hAAAA);
    queue_word(FUNC_ENQ, 16'hFFFF, 16'h5555);
    queue_word(FUNC_ENQ, 16'h0000, 16'hFFFF);
    repeat (8) queue_word(FUNC_DEQ, 16'h0000, 16'h0000);
    queue_word(FUNC_DEQ, 16'h5A5A, 16'hA5A5);

    // Random phases that lean towards filling, draining or neither, so the queue
    // repeatedly reaches both full and empty.
    queued = 0;
    while (queued < RANDOM_WORDS) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      repeat (phase_len) begin
        w.func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        case ($urandom_range(0, 7))
          0:       w.prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          1, 2:    w.prio = $urandom_range(0, 7);
          default: w.prio = $urandom;
        endcase
        w.tag = $urandom;
        pending_words.push_back(w);
      end
      queued += phase_len;
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || req_valid_i || results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
    end

    $display("Ran %0d enqueues (%0d refused as full) and %0d dequeues (%0d on empty).",
             enq_count, refused_full, deq_count, empty_deqs);
    $display("Deepest fill reached %0d of %0d entries; %0d mismatches over %0d cycles.",
             peak_fill, QDEPTH, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_unit.sv
src/spq_checker.sv
tb/sorted_priority_queue_unit_tb.sv
